FILE: hw/rtl/rmq_pkg.sv
// Shared widths, constants and types for the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 18;
  localparam int ONE       = 1 << FRAC_BITS;

  // Radicand and branch sums of three elements plus one.
  localparam int RAD_W  = FIELD_W + 3;
  // Magnitude of one vector component.
  localparam int MAG_W  = FIELD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  // Quotient never exceeds ONE, so one bit above the fraction suffices.
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int NUM_W  = MAG_W + FRAC_BITS + 1;

  localparam int PREP_STAGES = 3;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W + 1;

  typedef struct packed {
    logic                  degen;
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } rmq_vec_t;

  typedef struct packed {
    logic                degen;
    logic [3:0]          neg;
    logic [3:0][Q_W-1:0] quo;
  } rmq_quo_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmq_prep.sv
// Branch selection, component magnitudes, squares and their sum.
`default_nettype none
module rmq_prep import rmq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] r00,
  input  logic signed [FIELD_W-1:0] r01,
  input  logic signed [FIELD_W-1:0] r02,
  input  logic signed [FIELD_W-1:0] r10,
  input  logic signed [FIELD_W-1:0] r11,
  input  logic signed [FIELD_W-1:0] r12,
  input  logic signed [FIELD_W-1:0] r20,
  input  logic signed [FIELD_W-1:0] r21,
  input  logic signed [FIELD_W-1:0] r22,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SUM_W-1:0]          sumsq,
  output rmq_vec_t                  vec
);

  logic [PREP_STAGES-1:0] vld;
  logic [PREP_STAGES-1:0] take;

  rmq_vec_t             vec0, vec1, vec2, vec_next;
  logic [3:0][SQ_W-1:0] sq;
  logic [SUM_W-1:0]     sum;

  logic signed [RAD_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [RAD_W-1:0] trace, rad, one_r;
  logic signed [RAD_W-1:0] comp [4];

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [RAD_W-1:0] v);
    logic signed [RAD_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  assign take[PREP_STAGES-1] = !vld[PREP_STAGES-1] || !out_stall;
  for (genvar k = 0; k < PREP_STAGES - 1; k++) begin : g_take
    assign take[k] = !vld[k] || take[k+1];
  end
  assign in_stall  = !take[0];
  assign out_valid = vld[PREP_STAGES-1];

  always_comb begin
    e00 = RAD_W'(r00); e01 = RAD_W'(r01); e02 = RAD_W'(r02);
    e10 = RAD_W'(r10); e11 = RAD_W'(r11); e12 = RAD_W'(r12);
    e20 = RAD_W'(r20); e21 = RAD_W'(r21); e22 = RAD_W'(r22);
    one_r = RAD_W'(ONE);
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      rad = trace + one_r;
      comp[0] = rad;       comp[1] = e21 - e12;
      comp[2] = e02 - e20; comp[3] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      rad = one_r + e00 - e11 - e22;
      comp[0] = e21 - e12; comp[1] = rad;
      comp[2] = e01 + e10; comp[3] = e02 + e20;
    end else if (e11 > e22) begin
      rad = one_r + e11 - e00 - e22;
      comp[0] = e02 - e20; comp[1] = e01 + e10;
      comp[2] = rad;       comp[3] = e12 + e21;
    end else begin
      rad = one_r + e22 - e00 - e11;
      comp[0] = e10 - e01; comp[1] = e02 + e20;
      comp[2] = e12 + e21; comp[3] = rad;
    end
    vec_next.degen = (rad <= 0);
    for (int i = 0; i < 4; i++) begin
      vec_next.neg[i] = comp[i] < 0;
      vec_next.mag[i] = mag_of(comp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (take[0]) vld[0] <= in_valid;
      if (take[1]) vld[1] <= vld[0];
      if (take[2]) vld[2] <= vld[1];
    end
    if (take[0] && in_valid) begin
      vec0 <= vec_next;
    end
    if (take[1] && vld[0]) begin
      vec1 <= vec0;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= SQ_W'(vec0.mag[i]) * SQ_W'(vec0.mag[i]);
      end
    end
    if (take[2] && vld[1]) begin
      vec2 <= vec1;
      sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    end
  end

  assign sumsq = sum;
  assign vec   = vec2;

endmodule
`default_nettype wire

FILE: hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SUM_W-1:0]  sumsq,
  input  rmq_vec_t          in_vec,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROOT_W-1:0] root,
  output rmq_vec_t          out_vec
);

  logic [SQRT_STAGES-1:0] vld;
  logic [SQRT_STAGES-1:0] take;
  logic [SQRT_STAGES-1:0] feed;

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [SUM_W-1:0]  n_q    [SQRT_STAGES];
  rmq_vec_t          vec_q  [SQRT_STAGES];

  assign take[SQRT_STAGES-1] = !vld[SQRT_STAGES-1] || !out_stall;
  for (genvar k = 0; k < SQRT_STAGES - 1; k++) begin : g_take
    assign take[k] = !vld[k] || take[k+1];
  end
  assign in_stall  = !take[0];
  assign out_valid = vld[SQRT_STAGES-1];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  n_in;
    rmq_vec_t          vec_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign feed[k]  = in_valid;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign n_in     = sumsq;
      assign vec_in   = in_vec;
    end else begin : g_rest
      assign feed[k]  = vld[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign n_in     = n_q[k-1];
      assign vec_in   = vec_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4 + 1.
    assign cur   = {rem_in, n_in[SUM_W-1-2*k -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (take[k]) begin
        vld[k] <= feed[k];
      end
      if (take[k] && feed[k]) begin
        n_q[k]   <= n_in;
        vec_q[k] <= vec_in;
        if (cur >= trial) begin
          rem_q[k]  <= REM_W'(cur - trial);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= REM_W'(cur);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root    = root_q[SQRT_STAGES-1];
  assign out_vec = vec_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rmq_div.sv
// Four-lane pipelined rounding divider: quotient of |v| * ONE by the length.
`default_nettype none
module rmq_div import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ROOT_W-1:0] len,
  input  rmq_vec_t          in_vec,
  output logic              out_valid,
  input  logic              out_stall,
  output rmq_quo_t          result
);

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] take;

  logic [ROOT_W-1:0]            len_q [DIV_STAGES];
  logic [3:0][NUM_W-1:0]        num_q [DIV_STAGES];
  logic [3:0][ROOT_W-1:0]       rem_q [DIV_STAGES];
  logic [3:0][Q_W-1:0]          quo_q [DIV_STAGES];
  logic [DIV_STAGES-1:0]        degen_q;
  logic [3:0]                   neg_q [DIV_STAGES];

  assign take[DIV_STAGES-1] = !vld[DIV_STAGES-1] || !out_stall;
  for (genvar k = 0; k < DIV_STAGES - 1; k++) begin : g_take
    assign take[k] = !vld[k] || take[k+1];
  end
  assign in_stall  = !take[0];
  assign out_valid = vld[DIV_STAGES-1];

  // First stage forms the rounded numerators; a zero length is degenerate too.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (take[0]) begin
      vld[0] <= in_valid;
    end
    if (take[0] && in_valid) begin
      len_q[0]   <= len;
      degen_q[0] <= in_vec.degen || (len == '0);
      neg_q[0]   <= in_vec.neg;
      for (int i = 0; i < 4; i++) begin
        num_q[0][i] <= {1'b0, in_vec.mag[i], FRAC_BITS'(0)} + NUM_W'(len >> 1);
        rem_q[0][i] <= '0;
        quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    logic [3:0][ROOT_W-1:0] rem_in;
    logic [3:0][ROOT_W:0]   cur;

    // The quotient fits in Q_W bits, so the bits above it start the remainder.
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        if (k == 1) begin
          rem_in[i] = ROOT_W'(num_q[k-1][i][NUM_W-1:Q_W]);
        end else begin
          rem_in[i] = rem_q[k-1][i];
        end
        cur[i] = {rem_in[i], num_q[k-1][i][Q_W-k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (take[k]) begin
        vld[k] <= vld[k-1];
      end
      if (take[k] && vld[k-1]) begin
        len_q[k]   <= len_q[k-1];
        num_q[k]   <= num_q[k-1];
        degen_q[k] <= degen_q[k-1];
        neg_q[k]   <= neg_q[k-1];
        for (int i = 0; i < 4; i++) begin
          if (cur[i] >= {1'b0, len_q[k-1]}) begin
            rem_q[k][i] <= ROOT_W'(cur[i] - {1'b0, len_q[k-1]});
            quo_q[k][i] <= {quo_q[k-1][i][Q_W-2:0], 1'b1};
          end else begin
            rem_q[k][i] <= ROOT_W'(cur[i]);
            quo_q[k][i] <= {quo_q[k-1][i][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign result.degen = degen_q[DIV_STAGES-1];
  assign result.neg   = neg_q[DIV_STAGES-1];
  assign result.quo   = quo_q[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_quaternion_top.sv
// Top level: rotation matrix to unit quaternion pipeline with output register.
//
// Input channel: r00..r22 with in_valid/in_stall; a word is taken at a clock
// edge where in_valid is high and in_stall is low. Output channel: quat_w..z
// and degenerate with out_valid/out_stall, taken the same way.
// From acceptance to out_valid a word passes branch selection, squaring and
// summing, the square root (one root bit per stage), the four-lane divider
// (numerator setup then one quotient bit per stage), and the output register.
// Throughput is one word per cycle while the receiver does not stall.
// Every stage holds its own valid bit, so while the receiver stalls the empty
// stages behind the waiting word keep filling; in_stall rises only when all
// stages hold words. Synchronous reset clears all valid bits; data registers
// are not reset. A non-positive radicand or zero length gives the identity
// quaternion with degenerate set.
`default_nettype none
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] r00,
  input  logic signed [FIELD_W-1:0] r01,
  input  logic signed [FIELD_W-1:0] r02,
  input  logic signed [FIELD_W-1:0] r10,
  input  logic signed [FIELD_W-1:0] r11,
  input  logic signed [FIELD_W-1:0] r12,
  input  logic signed [FIELD_W-1:0] r20,
  input  logic signed [FIELD_W-1:0] r21,
  input  logic signed [FIELD_W-1:0] r22,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] quat_w,
  output logic signed [FIELD_W-1:0] quat_x,
  output logic signed [FIELD_W-1:0] quat_y,
  output logic signed [FIELD_W-1:0] quat_z,
  output logic                      degenerate
);

  logic              prep_valid, prep_stall;
  logic [SUM_W-1:0]  sumsq;
  rmq_vec_t          prep_vec;
  logic              sqrt_valid, sqrt_stall;
  logic [ROOT_W-1:0] len;
  rmq_vec_t          sqrt_vec;
  logic              div_valid, div_stall;
  rmq_quo_t          quo;

  logic                             take;
  logic [3:0][FIELD_W-1:0]          quat_next;
  logic [Q_W-1:0]                   clamped;
  logic [FIELD_W-1:0]               pos;

  rmq_prep u_prep (
    .clk, .rst, .in_valid, .in_stall,
    .r00, .r01, .r02, .r10, .r11, .r12, .r20, .r21, .r22,
    .out_valid (prep_valid),
    .out_stall (prep_stall),
    .sumsq     (sumsq),
    .vec       (prep_vec)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst,
    .in_valid  (prep_valid),
    .in_stall  (prep_stall),
    .sumsq     (sumsq),
    .in_vec    (prep_vec),
    .out_valid (sqrt_valid),
    .out_stall (sqrt_stall),
    .root      (len),
    .out_vec   (sqrt_vec)
  );

  rmq_div u_div (
    .clk, .rst,
    .in_valid  (sqrt_valid),
    .in_stall  (sqrt_stall),
    .len       (len),
    .in_vec    (sqrt_vec),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .result    (quo)
  );

  assign take      = !out_valid || !out_stall;
  assign div_stall = !take;

  always_comb begin
    clamped = '0;
    pos     = '0;
    for (int i = 0; i < 4; i++) begin
      clamped = (quo.quo[i] > Q_W'(ONE)) ? Q_W'(ONE) : quo.quo[i];
      pos     = FIELD_W'(clamped);
      if (quo.degen) begin
        quat_next[i] = (i == 0) ? FIELD_W'(ONE) : '0;
      end else if (quo.neg[i]) begin
        quat_next[i] = -pos;
      end else begin
        quat_next[i] = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= div_valid;
    end
    if (take && div_valid) begin
      quat_w     <= quat_next[0];
      quat_x     <= quat_next[1];
      quat_y     <= quat_next[2];
      quat_z     <= quat_next[3];
      degenerate <= quo.degen;
    end
  end

`ifndef SYNTHESIS
  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      quat_w == FIELD_W'(ONE) && quat_x == '0 && quat_y == '0 && quat_z == '0)
    else $error("degenerate word is not the identity quaternion");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side is free");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w <= FIELD_W'(ONE) && quat_w >= -FIELD_W'(ONE)
      && quat_x <= FIELD_W'(ONE) && quat_x >= -FIELD_W'(ONE))
    else $error("quaternion component outside unit range");
`endif

endmodule
`default_nettype wire
